[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

`endif

[rtl/itrd_pkg.sv]
package itrd_pkg;

  // Field widths fixed by the interface.
  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 7;

  // Radix limits and ASCII anchors.
  localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
  localparam logic [RADIX_W-1:0] DEC_MAX    = 6'd9;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0]  ASCII_A    = 7'd65;
  localparam logic [CHAR_W-1:0]  DEC_COUNT  = 7'd10;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // load a new value and radix
    logic step;      // one restoring division step
    logic rd;        // read the digit buffer at the readout index
    logic load_out;  // move the read digit into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_zero;    // incoming value is zero
    logic div_last;   // this step finishes one division
    logic quot_zero;  // quotient after this step is zero
    logic out_free;   // output register can take a digit this cycle
    logic rd_last;    // readout index points at the least significant digit
  } dp_status_t;

  // Out-of-range radix codes clamp to the nearest legal base.
  function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  // Digit value to its ASCII character.
  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d > DEC_MAX) begin
      res = ASCII_A + CHAR_W'(d) - DEC_COUNT;
    end else begin
      res = ASCII_ZERO + CHAR_W'(d);
    end
    return res;
  endfunction

endpackage

[rtl/itrd_ctrl.sv]
module itrd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  itrd_pkg::dp_status_t sts_i,
  output itrd_pkg::ctrl_cmd_t  cmd_o
);
  import itrd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_LOAD
  } state_e;

  state_e state_q, state_d;

  // Next state and datapath commands.
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    unique case (state_q)
      ST_IDLE: begin
        // A zero value is taken and produces no digits.
        if (in_valid_i && !sts_i.in_zero) begin
          cmd_o.start = 1'b1;
          state_d     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (sts_i.div_last && sts_i.quot_zero) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = sts_i.rd_last ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // One conversion at a time.
  assign in_stall_o = (state_q != ST_IDLE);

endmodule

[rtl/itrd_dp.sv]
`include "assert_macros.svh"

module itrd_dp #(
  parameter int VALUE_BITS = 31
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [VALUE_BITS-1:0]       value_i,
  input  logic [itrd_pkg::RADIX_W-1:0] radix_i,
  input  itrd_pkg::ctrl_cmd_t         cmd_i,
  output itrd_pkg::dp_status_t        sts_o,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic [itrd_pkg::CHAR_W-1:0] digit_char_o,
  output logic                        last_digit_o
);
  import itrd_pkg::*;

  localparam int BIT_W = $clog2(VALUE_BITS);
  localparam int IDX_W = $clog2(VALUE_BITS);
  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] quot_q;
  logic [RADIX_W-1:0]    rem_q;
  logic [RADIX_W-1:0]    radix_q;
  logic [BIT_W-1:0]      bit_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic [RADIX_W-1:0]    rd_data_q;
  logic [CHAR_W-1:0]     char_q;
  logic                  last_q;
  logic                  out_valid_q;

  logic [RADIX_W-1:0]    digit_mem [VALUE_BITS];

  logic [RADIX_W:0]      trial;
  logic                  trial_ge;
  logic [RADIX_W-1:0]    rem_next;
  logic [VALUE_BITS-1:0] quot_next;
  logic                  out_take;

  // Restoring division step: bring down the next dividend bit.
  assign trial     = {rem_q, quot_q[VALUE_BITS-1]};
  assign trial_ge  = (trial >= {1'b0, radix_q});
  assign rem_next  = trial_ge ? RADIX_W'(trial - {1'b0, radix_q}) : trial[RADIX_W-1:0];
  assign quot_next = {quot_q[VALUE_BITS-2:0], trial_ge};

  assign out_take = out_valid_q && !out_stall_i;

  // Status toward the controller.
  always_comb begin
    sts_o.in_zero   = (value_i == '0);
    sts_o.div_last  = (bit_q == '0);
    sts_o.quot_zero = (quot_next == '0);
    sts_o.out_free  = !out_valid_q || !out_stall_i;
    sts_o.rd_last   = (rd_idx_q == '0);
  end

  // Control registers: remainder, radix, step counter, digit count, readout index, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      radix_q     <= RADIX_MIN;
      bit_q       <= '0;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        rem_q   <= '0;
        radix_q <= sat_radix(radix_i);
        bit_q   <= BIT_W'(VALUE_BITS - 1);
        cnt_q   <= '0;
      end else if (cmd_i.step) begin
        if (bit_q == '0) begin
          // Division done: the remainder is the next digit.
          rem_q    <= '0;
          bit_q    <= BIT_W'(VALUE_BITS - 1);
          cnt_q    <= cnt_q + CNT_W'(1);
          rd_idx_q <= cnt_q[IDX_W-1:0];
        end else begin
          rem_q <= rem_next;
          bit_q <= bit_q - BIT_W'(1);
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
        if (rd_idx_q != '0) begin
          rd_idx_q <= rd_idx_q - IDX_W'(1);
        end
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: quotient, digit buffer, read data, output digit and last flag.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      quot_q <= value_i;
    end else if (cmd_i.step) begin
      quot_q <= quot_next;
    end
    if (cmd_i.step && (bit_q == '0)) begin
      digit_mem[cnt_q[IDX_W-1:0]] <= rem_next;
    end
    if (cmd_i.rd) begin
      rd_data_q <= digit_mem[rd_idx_q];
    end
    if (cmd_i.load_out) begin
      char_q <= digit_ascii(rd_data_q);
      last_q <= (rd_idx_q == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = char_q;
  assign last_digit_o = last_q;

  // The partial remainder always stays below the radix.
  `ASSERT_CLK_RST(a_rem_below_radix, clk_i, rst_ni, rem_q < radix_q, "remainder reached radix")
  // The digit count never exceeds the value width.
  `ASSERT_CLK_RST(a_cnt_bound, clk_i, rst_ni, cnt_q <= CNT_W'(VALUE_BITS), "digit count overflow")
  // A digit is only loaded when the output register is free.
  `ASSERT_IMPLY(a_load_free, clk_i, rst_ni, cmd_i.load_out, !out_valid_q || !out_stall_i, "digit overwritten")
  // The readout index points at a written buffer entry.
  `ASSERT_IMPLY(a_rd_idx, clk_i, rst_ni, cmd_i.rd, CNT_W'(rd_idx_q) < cnt_q, "read beyond digits")

endmodule

[rtl/integer_to_radix_digits.sv]
// Integer to radix digit string converter.
// Input channel: value_i and radix_i transfer when in_valid_i is high and
// in_stall_o is low. Radix codes below 2 act as 2, codes above 36 act as 36.
// Output channel: one transfer per digit, most significant first, while
// out_valid_o is high and out_stall_i is low. digit_char_o is the ASCII
// character and last_digit_o marks the least significant, final digit.
// A zero value is taken and produces no digits.
// The value is divided by the radix again and again, one quotient bit per
// cycle in a single restoring divider, each remainder being one digit; the
// digits are then read out of the digit buffer by a registered read and an output load.
// A new item is taken once the last digit sits in the output register.
// While the receiver stalls the output digit holds and readout pauses.
// Reset clears the controller to idle and empties the output register.
module integer_to_radix_digits #(
  parameter int VALUE_BITS = 31
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [VALUE_BITS-1:0]        value_i,
  input  logic [itrd_pkg::RADIX_W-1:0] radix_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [itrd_pkg::CHAR_W-1:0]  digit_char_o,
  output logic                         last_digit_o
);
  import itrd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // Sequencer for division and readout.
  itrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Divider, digit buffer and output register.
  itrd_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (value_i),
    .radix_i      (radix_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o)
  );

endmodule
